>>> rtl/uart_transmitter_with_fifo_defines.svh
// Assertion macros for the UART transmitter block.
`ifndef UART_TRANSMITTER_WITH_FIFO_DEFINES_SVH
`define UART_TRANSMITTER_WITH_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTXF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTXF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/utxf_pkg.sv
`timescale 1ns / 1ps

package utxf_pkg;

    localparam int DEF_FIFO_DEPTH = 16;

    localparam int CPB_W       = 16;
    localparam int DBITS_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int LEVEL_W     = 5;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CPB_W-1:0]   CPB_RESET   = 16'd868;
    localparam logic [DBITS_W-1:0] DBITS_RESET = 4'd8;

    // register indexes on the config channel
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLES_PER_BIT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_BITS      = 4'd1;

    // item kind carried on tuser
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_ENQUEUE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DATA     = 4'b0010,
        PH_STOP     = 4'b0100,
        PH_STOPPING = 4'b1000
    } tx_phase_t;

    // result item, tx_line in the lowest bit
    typedef struct packed {
        logic [LEVEL_W-1:0] fifo_level;
        logic               dropped;
        logic               busy_res;
        logic               tx_line;
    } result_t;

endpackage

>>> rtl/utxf_ram.sv
`timescale 1ns / 1ps

module utxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/uart_transmitter_with_fifo.sv
`timescale 1ns / 1ps
// UART 8N1-style transmitter with a byte FIFO, fed one item per clock if ready.
// The result for an item is registered onto m_axis, or into the skid entry.
// Throughput: one item per cycle while m_axis_tready keeps up; a two-entry
// output buffer keeps s_axis_tready high while a single result waits.
// Reset (rst_n low, async): idle, line high, FIFO empty, registers at defaults.
// FIFO contents need no clearing, so items are accepted right after reset.

module uart_transmitter_with_fifo
    import utxf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] tx_byte
    input  logic                   s_axis_tuser,   // [0] req_type

    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [0] tx_line, [1] busy_res,
                                                   // [2] dropped, [7:3] fifo_level

    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CPB_W-1:0]       cfg_data
);

    `include "uart_transmitter_with_fifo_defines.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [CPB_W-1:0]   cycles_per_bit_reg;
    logic [DBITS_W-1:0] data_bits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_per_bit_reg <= CPB_RESET;
            data_bits_reg      <= DBITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CYCLES_PER_BIT: cycles_per_bit_reg <= cfg_data;
                REG_DATA_BITS:      data_bits_reg      <= cfg_data[DBITS_W-1:0];
                default:            ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Transmitter state
    // ------------------------------------------------------------------
    tx_phase_t          phase_reg, phase_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DBITS_W-1:0] bit_index_reg, bit_index_next;
    logic [CPB_W-1:0]   bit_timer_reg, bit_timer_next;
    logic               line_level_reg, line_level_next;
    logic [BYTE_W-1:0]  shift_byte_reg, shift_byte_next;
    // set for one cycle after a pop from the RAM; the byte is on rd_data then
    logic               load_pending_reg, load_pending_next;

    logic               in_fire;
    logic               is_enq;
    logic               dropped;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [BYTE_W-1:0]  ram_rd_data;
    logic [BYTE_W-1:0]  byte_src;
    logic [CPB_W-1:0]   period;
    logic [CPB_W-1:0]   timer_dec;
    logic [DBITS_W-1:0] index_inc;
    logic               data_bit;
    result_t            result;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign is_enq    = (s_axis_tuser == REQ_ENQUEUE);
    assign period    = (cycles_per_bit_reg == '0) ? CPB_W'(1) : cycles_per_bit_reg;
    assign byte_src  = load_pending_reg ? ram_rd_data : shift_byte_reg;
    assign timer_dec = (bit_timer_reg != '0) ? (bit_timer_reg - CPB_W'(1)) : '0;
    assign index_inc = bit_index_reg + DBITS_W'(1);
    // bits above bit 7 of a long frame go out as zeros
    assign data_bit  = bit_index_reg[3] ? 1'b0 : byte_src[bit_index_reg[2:0]];

    always_comb
    begin
        phase_next        = phase_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        count_next        = count_reg;
        bit_index_next    = bit_index_reg;
        bit_timer_next    = bit_timer_reg;
        line_level_next   = line_level_reg;
        shift_byte_next   = load_pending_reg ? ram_rd_data : shift_byte_reg;
        load_pending_next = 1'b0;
        dropped           = 1'b0;
        ram_wr_en         = 1'b0;
        ram_rd_en         = 1'b0;

        if (in_fire && is_enq)
        begin
            if (count_reg == CNT_FULL)
            begin
                dropped = 1'b1;
            end
            else if (phase_reg == PH_IDLE)
            begin
                // idle means the FIFO is empty: push and pop cancel, send at once
                ram_wr_en       = 1'b1;
                wr_ptr_next     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
                rd_ptr_next     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
                shift_byte_next = s_axis_tdata;
                line_level_next = 1'b0;
                bit_index_next  = '0;
                bit_timer_next  = period;
                phase_next      = PH_DATA;
            end
            else
            begin
                ram_wr_en   = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else if (in_fire && (phase_reg != PH_IDLE))
        begin
            bit_timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        line_level_next = data_bit;
                        bit_timer_next  = period;
                        bit_index_next  = index_inc;
                        if (index_inc >= data_bits_reg)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        line_level_next = 1'b1;
                        bit_timer_next  = period;
                        phase_next      = PH_STOPPING;
                    end
                    PH_STOPPING:
                    begin
                        if (count_reg != '0)
                        begin
                            // pop: byte arrives from the RAM next cycle
                            ram_rd_en         = 1'b1;
                            load_pending_next = 1'b1;
                            rd_ptr_next       = (rd_ptr_reg == PTR_LAST) ? '0
                                                : rd_ptr_reg + PTR_W'(1);
                            count_next        = count_reg - CNT_W'(1);
                            line_level_next   = 1'b0;
                            bit_index_next    = '0;
                            bit_timer_next    = period;
                            phase_next        = PH_DATA;
                        end
                        else
                        begin
                            phase_next      = PH_IDLE;
                            bit_timer_next  = '0;
                            line_level_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next      = PH_IDLE;
                        line_level_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            count_reg        <= '0;
            bit_index_reg    <= '0;
            bit_timer_reg    <= '0;
            line_level_reg   <= 1'b1;
            load_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            count_reg        <= count_next;
            bit_index_reg    <= bit_index_next;
            bit_timer_reg    <= bit_timer_next;
            line_level_reg   <= line_level_next;
            load_pending_reg <= load_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_byte_reg <= shift_byte_next;
    end

    utxf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result buffer: output register plus one skid entry
    // ------------------------------------------------------------------
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    out_fire;

    assign result.tx_line    = line_level_next;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.dropped    = dropped;
    assign result.fifo_level = LEVEL_W'(count_next);

    assign s_axis_tready = !skid_valid_reg;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (out_valid_reg)
        begin
            if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            out_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_fire && (out_fire || !out_valid_reg))
        begin
            out_data_reg <= result;
        end
        if (in_fire && out_valid_reg && !out_fire)
        begin
            skid_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `UTXF_ASSERT_NOW(a_idle_fifo_empty, clk, rst_n, phase_reg == PH_IDLE,
        count_reg == '0 && line_level_reg, "idle with bytes waiting or line low")
    `UTXF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL,
        "FIFO count above depth")
    `UTXF_ASSERT_NOW(a_load_in_data, clk, rst_n, load_pending_reg,
        phase_reg == PH_DATA, "RAM byte load outside the data phase")
    `UTXF_ASSERT_NOW(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held with empty output register")
    `UTXF_ASSERT_NEXT(a_pop_start_bit, clk, rst_n, ram_rd_en,
        !line_level_reg && bit_index_reg == '0, "pop without start bit")

endmodule
